// ===== sv/esr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esr_pkg
// Shared types and constants for the encoder speed regulator: payload words,
// controller states, command and status bundles.
// ----------------------------------------------------------------------------
package esr_pkg;

   localparam int unsigned MUL_STEPS = 32;
   localparam int unsigned DIV_STEPS = 24;
   localparam int unsigned CNT_W     = $clog2(MUL_STEPS);

   localparam logic [31:0] SCALE_FACTOR_RESET = 32'd6553600;
   localparam logic [23:0] LOOP_GAIN_RESET    = 24'd83886;

   localparam logic signed [23:0] RPM_MAX    = 24'sh7FFFFF;
   localparam logic signed [23:0] RPM_MIN    = 24'sh800000;
   localparam logic signed [15:0] DRIVE_FULL = 16'sd32767;

   typedef enum logic {
      CSR_SCALE_FACTOR = 1'b0,
      CSR_LOOP_GAIN    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               op;
      logic signed [23:0] target_rpm;
      logic signed [31:0] encoder_count;
      logic        [31:0] time_ms;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] drive_level;
      logic               drive_write;
      logic signed [23:0] measured_rpm;
      logic               measured_valid;
      logic               stalled;
      logic               zero_interval;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_RANGE,
      ST_DIV,
      ST_SPEED,
      ST_GAIN,
      ST_DRIVE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic range_check;
      logic div_step;
      logic set_speed;
      logic gain_mult;
      logic drive_update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic dt_zero;
      logic op_query;
      logic mul_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/esr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esr_ctrl
// Sequencer for one word: measure (shift-add multiply, restoring divide),
// saturate, apply the integral step, then hand the result to the output stage.
// ----------------------------------------------------------------------------
module esr_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  esr_pkg::status_type  status,
   output esr_pkg::cmd_type     cmd
);
   import esr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.skip)         state_in = ST_EMIT;
            else if (status.dt_zero) state_in = ST_SPEED;
            else                     state_in = ST_MUL;
         end
         ST_MUL: begin
            if (status.mul_last) state_in = ST_RANGE;
         end
         ST_RANGE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_SPEED;
         end
         ST_SPEED: begin
            if (status.op_query) state_in = ST_EMIT;
            else                 state_in = ST_GAIN;
         end
         ST_GAIN: begin
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            cmd.load  = req_valid && !reset;
         end
         ST_CHECK: begin
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
         end
         ST_RANGE: begin
            cmd.range_check = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_SPEED: begin
            cmd.set_speed = 1'b1;
         end
         ST_GAIN: begin
            cmd.gain_mult = 1'b1;
         end
         ST_DRIVE: begin
            cmd.drive_update = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/esr_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esr_dp
// Datapath: stored count, time and drive, 32-step shift-add multiplier,
// 24-step restoring divider sharing one product register, gain multiply,
// drive clamp and the output word register.
// ----------------------------------------------------------------------------
module esr_dp (
   input  wire                       clock,
   input  wire                       reset,
   input  esr_pkg::req_payload_type  req_data,
   input  wire                [31:0] scale_factor,
   input  wire                [23:0] loop_gain,
   input  esr_pkg::cmd_type          cmd,
   output esr_pkg::status_type       status,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output esr_pkg::rsp_payload_type  rsp_data
);
   import esr_pkg::*;

   logic        [31:0] prev_count_ff;
   logic        [31:0] prev_time_ff;
   logic signed [15:0] held_ff;
   logic signed [15:0] held_in;
   logic               op_ff;
   logic               skip_ff;
   logic signed [23:0] target_ff;
   logic        [31:0] dt_ff;
   logic               dt_zero_ff;
   logic               dc_neg_ff;
   logic               dc_zero_ff;
   logic               ovf_ff;
   logic        [63:0] prod_ff;
   logic        [63:0] prod_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic signed [23:0] speed_ff;
   logic signed [23:0] speed_in;
   logic signed [48:0] gprod_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;
   rsp_payload_type    rsp_in;

   logic        [31:0] dc_w;
   logic        [31:0] dt_w;
   logic        [31:0] mag_w;
   logic               skip_w;
   logic        [32:0] mul_sum;
   logic        [39:0] divisor;
   logic        [40:0] trial;
   logic               qbit;
   logic        [40:0] rem_w;
   logic        [23:0] quo;
   logic signed [48:0] err_x;
   logic signed [48:0] gain_x;
   logic signed [33:0] drive_sum;

   assign dc_w   = req_data.encoder_count - prev_count_ff;
   assign dt_w   = req_data.time_ms - prev_time_ff;
   assign mag_w  = dc_w[31] ? (32'd0 - dc_w) : dc_w;
   assign skip_w = !req_data.op && (req_data.target_rpm == 24'sd0);

   assign mul_sum = {1'b0, prod_ff[63:32]} + (prod_ff[0] ? {1'b0, scale_factor} : 33'd0);
   assign divisor = {dt_ff, 8'd0};
   assign trial   = prod_ff[63:23];
   assign qbit    = trial >= {1'b0, divisor};
   assign rem_w   = qbit ? (trial - {1'b0, divisor}) : trial;
   assign quo     = prod_ff[23:0];

   always_comb begin
      prod_in = prod_ff;
      if (cmd.load) begin
         prod_in = {32'd0, mag_w};
      end else if (cmd.mul_step) begin
         prod_in = {mul_sum, prod_ff[31:1]};
      end else if (cmd.div_step) begin
         prod_in = {rem_w[39:0], prod_ff[22:0], qbit};
      end
   end

   always_comb begin
      if (dt_zero_ff) begin
         if (dc_zero_ff)     speed_in = 24'sd0;
         else if (dc_neg_ff) speed_in = RPM_MIN;
         else                speed_in = RPM_MAX;
      end else if (ovf_ff) begin
         speed_in = dc_neg_ff ? RPM_MIN : RPM_MAX;
      end else if (dc_neg_ff) begin
         speed_in = (quo > 24'd8388608) ? RPM_MIN : $signed(24'd0 - quo);
      end else begin
         speed_in = (quo > 24'd8388607) ? RPM_MAX : $signed(quo);
      end
   end

   assign err_x  = {{25{target_ff[23]}}, target_ff} - {{25{speed_ff[23]}}, speed_ff};
   assign gain_x = $signed({25'd0, loop_gain});

   assign drive_sum = {{18{held_ff[15]}}, held_ff} + {{2{gprod_ff[48]}}, gprod_ff[48:17]};

   always_comb begin
      if (drive_sum > 34'sd32767)       held_in = DRIVE_FULL;
      else if (drive_sum < -34'sd32767) held_in = -DRIVE_FULL;
      else                              held_in = drive_sum[15:0];
   end

   always_comb begin
      rsp_in.drive_level    = (op_ff || skip_ff) ? 16'sd0 : held_ff;
      rsp_in.drive_write    = !op_ff;
      rsp_in.measured_rpm   = skip_ff ? 24'sd0 : speed_ff;
      rsp_in.measured_valid = !skip_ff;
      rsp_in.stalled        = op_ff && (speed_ff == 24'sd0);
      rsp_in.zero_interval  = !skip_ff && dt_zero_ff;
   end

   // stored state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (cmd.load && !skip_w) begin
            prev_count_ff <= req_data.encoder_count;
            prev_time_ff  <= req_data.time_ms;
         end
         if (cmd.drive_update) held_ff <= held_in;
         if (cmd.emit)            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)     rsp_valid_ff <= 1'b0;
         if (cmd.load || cmd.range_check)   cnt_ff <= '0;
         else if (cmd.mul_step || cmd.div_step) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         op_ff      <= req_data.op;
         skip_ff    <= skip_w;
         target_ff  <= req_data.target_rpm;
         dt_ff      <= dt_w;
         dt_zero_ff <= (dt_w == 32'd0);
         dc_neg_ff  <= dc_w[31];
         dc_zero_ff <= (dc_w == 32'd0);
         ovf_ff     <= 1'b0;
      end
      if (cmd.range_check) ovf_ff <= prod_ff[63:24] >= divisor;
      if (cmd.set_speed)   speed_ff <= speed_in;
      if (cmd.gain_mult)   gprod_ff <= err_x * gain_x;
      if (cmd.emit)        rsp_ff <= rsp_in;
   end

   assign status.skip     = skip_ff;
   assign status.dt_zero  = dt_zero_ff;
   assign status.op_query = op_ff;
   assign status.mul_last = cnt_ff == CNT_W'(MUL_STEPS - 1);
   assign status.div_last = cnt_ff == CNT_W'(DIV_STEPS - 1);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/encoder_speed_regulator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_regulator_core
// Integral speed regulator fed by encoder count and millisecond time stamps.
// ----------------------------------------------------------------------------
// One word is in work at a time. A measuring regulate word is taken, checked,
// passes the shift-add count-times-scale multiply, the range check and the
// restoring divide by the time delta, then is saturated, forms the gain
// product, clamps the drive and loads the result register; a query word skips
// the gain product and the drive clamp. A zero time delta skips multiply, range
// check and divide; a regulate word with zero target goes from the check
// straight to loading the result register. A stalled result keeps the next
// result from loading until the output register is free. A finished result
// waits in the output register while the next word is taken. Write registers
// only while no word is in work.
module encoder_speed_regulator_core (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  esr_pkg::req_payload_type  req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output esr_pkg::rsp_payload_type  rsp_data,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  esr_pkg::csr_index_type    csr_index,
   input  wire                [31:0] csr_data
);
   import esr_pkg::*;

   logic [31:0] scale_factor_ff;
   logic [23:0] loop_gain_ff;
   cmd_type     cmd;
   status_type  status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= SCALE_FACTOR_RESET;
         loop_gain_ff    <= LOOP_GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCALE_FACTOR: scale_factor_ff <= csr_data;
            CSR_LOOP_GAIN:    loop_gain_ff    <= csr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   esr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   esr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .scale_factor (scale_factor_ff),
      .loop_gain    (loop_gain_ff),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire
